FILE: rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent checks sampled on i_clk and held off while i_rst_n is low.
`define ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

`define ASSERT_IMPLIES(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/tccw_pkg.sv
`timescale 1ns / 1ps

package tccw_pkg;

    localparam int MAX_COLUMNS_DEF = 128;
    localparam int MAX_ROWS_DEF    = 32;
    localparam int TAB_STOP_DEF    = 8;

    localparam int ACTION_W   = 2;
    localparam int CHAR_W     = 8;
    localparam int INDEX_W    = 12;
    localparam int COL_OUT_W  = 7;
    localparam int ROW_OUT_W  = 5;
    localparam int CELL_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 32;

    localparam logic [ACTION_W-1:0] ACT_PUT   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

    localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;

    localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FOREGROUND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMNS    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS       = 2'd3;

    localparam logic [3:0] BACKGROUND_RESET = 4'd0;
    localparam logic [3:0] FOREGROUND_RESET = 4'd7;
    localparam logic [7:0] COLUMNS_RESET    = 8'd80;
    localparam logic [5:0] ROWS_RESET       = 6'd25;

    typedef struct packed {
        logic [3:0] background;
        logic [3:0] foreground;
        logic [7:0] columns;
        logic [5:0] rows;
    } t_cfg;

    typedef struct packed {
        logic [INDEX_W-1:0]  cell_index;
        logic [CHAR_W-1:0]   char_code;
        logic [ACTION_W-1:0] action;
    } t_item;

    typedef struct packed {
        logic [7:0]           read_attribute;
        logic [CHAR_W-1:0]    read_char;
        logic [ROW_OUT_W-1:0] cursor_row;
        logic [COL_OUT_W-1:0] cursor_column;
    } t_result;

endpackage

FILE: rtl/core/tccw_ram.sv
`timescale 1ns / 1ps

module tccw_ram #(
    parameter int WIDTH = tccw_pkg::CELL_W,
    parameter int DEPTH = tccw_pkg::MAX_COLUMNS_DEF * tccw_pkg::MAX_ROWS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/tccw_seq.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tccw_seq #(
    parameter int MAX_COLUMNS = tccw_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = tccw_pkg::MAX_ROWS_DEF,
    parameter int TAB_STOP    = tccw_pkg::TAB_STOP_DEF
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  tccw_pkg::t_cfg                                  i_cfg,
    input  logic                                            i_valid,
    input  tccw_pkg::t_item                                 i_item,
    output logic                                            o_ready,
    input  logic                                            i_out_free,
    output logic                                            o_done,
    output tccw_pkg::t_result                               o_res,
    output logic                                            o_mem_we,
    output logic [$clog2(MAX_COLUMNS*MAX_ROWS)-1:0]         o_mem_waddr,
    output logic [tccw_pkg::CELL_W-1:0]                     o_mem_wdata,
    output logic [$clog2(MAX_COLUMNS*MAX_ROWS)-1:0]         o_mem_raddr,
    input  logic [tccw_pkg::CELL_W-1:0]                     i_mem_rdata
);

    localparam int DEPTH     = MAX_COLUMNS * MAX_ROWS;
    localparam int AW        = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int CW        = $clog2(MAX_COLUMNS);
    localparam int RW        = $clog2(MAX_ROWS);
    localparam int NCW       = $clog2(MAX_COLUMNS + 1);
    localparam int NRW       = $clog2(MAX_ROWS + 1);
    localparam int CXW       = $clog2(MAX_COLUMNS + TAB_STOP + 1);
    localparam int RECIP_SH  = 16;
    localparam int RECIP     = (2 ** RECIP_SH + TAB_STOP - 1) / TAB_STOP;
    localparam int RCP_W     = $clog2(RECIP + 1);
    localparam int PROD_W    = CW + RCP_W;
    localparam int APROD_W   = RW + NCW;
    localparam int TPROD_W   = NRW + NCW;
    localparam int CELL_W    = tccw_pkg::CELL_W;
    localparam int CHAR_W    = tccw_pkg::CHAR_W;
    localparam int COL_OUT_W = tccw_pkg::COL_OUT_W;
    localparam int ROW_OUT_W = tccw_pkg::ROW_OUT_W;

    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_APPLY  = 3'd2;
    localparam logic [2:0] S_SCROLL = 3'd3;
    localparam logic [2:0] S_CLEAR  = 3'd4;
    localparam logic [2:0] S_OUT    = 3'd5;

    logic [2:0]                    r_state, n_state;
    logic [CNT_W-1:0]              r_cnt, n_cnt;
    logic                          r_wpend, n_wpend;
    logic [AW-1:0]                 r_waddr;
    logic [CW-1:0]                 r_col;
    logic [RW-1:0]                 r_row;

    logic [tccw_pkg::ACTION_W-1:0] r_act;
    logic [CHAR_W-1:0]             r_ch;
    logic [CW-1:0]                 r_colc;
    logic [RW-1:0]                 r_rowc;
    logic [AW-1:0]                 r_addr;
    logic [CW-1:0]                 r_q;
    logic [NCW-1:0]                r_nc;
    logic [NRW-1:0]                r_nr;
    logic [CNT_W-1:0]              r_total;
    logic                          r_rdok;
    tccw_pkg::t_result             r_res, n_res;

    logic [NCW-1:0]                eff_nc;
    logic [NRW-1:0]                eff_nr;
    logic [CW-1:0]                 col_c;
    logic [RW-1:0]                 row_c;
    logic [APROD_W-1:0]            addr_prod;
    logic [PROD_W-1:0]             tab_prod;
    logic [TPROD_W-1:0]            total_prod;
    logic                          accept;

    logic [CXW-1:0]                ncol;
    logic [NRW-1:0]                nrow;
    logic                          put_we;
    logic                          scroll;
    logic                          upd;
    logic [CW-1:0]                 cur_col;
    logic [RW-1:0]                 cur_row;
    logic [CNT_W-1:0]              moved;
    logic                          copy;

    // Screen size and cursor clamp for the next item.
    always_comb begin
        if (i_cfg.columns == 8'd0) begin
            eff_nc = NCW'(1);
        end else if (32'(i_cfg.columns) > 32'(MAX_COLUMNS)) begin
            eff_nc = NCW'(MAX_COLUMNS);
        end else begin
            eff_nc = NCW'(i_cfg.columns);
        end
        if (i_cfg.rows == 6'd0) begin
            eff_nr = NRW'(1);
        end else if (32'(i_cfg.rows) > 32'(MAX_ROWS)) begin
            eff_nr = NRW'(MAX_ROWS);
        end else begin
            eff_nr = NRW'(i_cfg.rows);
        end
        if (CXW'(r_col) >= CXW'(eff_nc)) begin
            col_c = CW'(eff_nc - NCW'(1));
        end else begin
            col_c = r_col;
        end
        if (NRW'(r_row) >= eff_nr) begin
            row_c = RW'(eff_nr - NRW'(1));
        end else begin
            row_c = r_row;
        end
        addr_prod  = APROD_W'(row_c) * APROD_W'(eff_nc);
        tab_prod   = PROD_W'(col_c) * PROD_W'(RECIP);
        total_prod = TPROD_W'(eff_nr) * TPROD_W'(eff_nc);
    end

    assign accept  = i_valid && (r_state == S_IDLE);
    assign o_ready = (r_state == S_IDLE);

    // Cursor movement of a put.
    always_comb begin
        ncol   = CXW'(r_colc);
        nrow   = NRW'(r_rowc);
        put_we = 1'b0;
        scroll = 1'b0;
        upd    = (r_act == tccw_pkg::ACT_PUT) && (r_ch != tccw_pkg::CH_NUL);
        if (upd) begin
            case (r_ch)
                tccw_pkg::CH_TAB: begin
                    ncol = CXW'((CXW'(r_q) + CXW'(1)) * CXW'(TAB_STOP));
                end
                tccw_pkg::CH_NEWLINE: begin
                    ncol = '0;
                    nrow = nrow + NRW'(1);
                end
                default: begin
                    put_we = 1'b1;
                    ncol   = ncol + CXW'(1);
                end
            endcase
            if (ncol >= CXW'(r_nc)) begin
                ncol = '0;
                nrow = nrow + NRW'(1);
            end
            if (nrow >= r_nr) begin
                nrow   = r_nr - NRW'(1);
                scroll = 1'b1;
            end
        end
        cur_col = upd ? CW'(ncol) : r_col;
        cur_row = upd ? RW'(nrow) : r_row;

        n_res.cursor_column  = COL_OUT_W'(cur_col);
        n_res.cursor_row     = ROW_OUT_W'(cur_row);
        n_res.read_char      = '0;
        n_res.read_attribute = '0;
        if ((r_act == tccw_pkg::ACT_READ) && r_rdok) begin
            n_res.read_char      = i_mem_rdata[CHAR_W-1:0];
            n_res.read_attribute = i_mem_rdata[CELL_W-1:CHAR_W];
        end
    end

    assign moved = r_total - CNT_W'(r_nc);
    assign copy  = (r_cnt < moved);

    // Memory port selection.
    always_comb begin
        o_mem_we    = 1'b0;
        o_mem_waddr = AW'(r_cnt);
        o_mem_wdata = '0;
        o_mem_raddr = AW'(i_item.cell_index);
        case (r_state)
            S_INIT: begin
                o_mem_we = 1'b1;
            end
            S_APPLY: begin
                o_mem_we    = put_we;
                o_mem_waddr = r_addr;
                o_mem_wdata = {i_cfg.background, i_cfg.foreground, r_ch};
            end
            S_SCROLL: begin
                o_mem_raddr = AW'(r_cnt + CNT_W'(r_nc));
                if (r_wpend) begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = r_waddr;
                    o_mem_wdata = i_mem_rdata;
                end else if (!copy && (r_cnt < r_total)) begin
                    o_mem_we = 1'b1;
                end
            end
            S_CLEAR: begin
                o_mem_we = (r_cnt < r_total);
            end
            default: begin
                o_mem_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_wpend = 1'b0;
        o_done  = 1'b0;
        case (r_state)
            S_INIT: begin
                if (r_cnt == CNT_W'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                n_cnt = '0;
                if (r_act == tccw_pkg::ACT_CLEAR) begin
                    n_state = S_CLEAR;
                end else if (scroll) begin
                    n_state = S_SCROLL;
                end else if (i_out_free) begin
                    o_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_SCROLL: begin
                if (copy) begin
                    n_wpend = 1'b1;
                    n_cnt   = r_cnt + CNT_W'(1);
                end else if (r_wpend) begin
                    n_cnt = r_cnt;
                end else if (r_cnt < r_total) begin
                    n_cnt = r_cnt + CNT_W'(1);
                end else begin
                    n_state = S_OUT;
                end
            end
            S_CLEAR: begin
                if (r_cnt < r_total) begin
                    n_cnt = r_cnt + CNT_W'(1);
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_out_free) begin
                    o_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_res = (r_state == S_APPLY) ? n_res : r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_cnt   <= '0;
            r_wpend <= 1'b0;
            r_col   <= '0;
            r_row   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_wpend <= n_wpend;
            if (r_state == S_APPLY) begin
                r_col <= cur_col;
                r_row <= cur_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_waddr <= AW'(r_cnt);
        if (accept) begin
            r_act   <= i_item.action;
            r_ch    <= i_item.char_code;
            r_colc  <= col_c;
            r_rowc  <= row_c;
            r_addr  <= AW'(addr_prod) + AW'(col_c);
            r_q     <= CW'(tab_prod >> RECIP_SH);
            r_nc    <= eff_nc;
            r_nr    <= eff_nr;
            r_total <= CNT_W'(total_prod);
            r_rdok  <= (32'(i_item.cell_index) < 32'(DEPTH));
        end
        if (r_state == S_APPLY) begin
            r_res <= n_res;
        end
    end

    `ASSERT_IMPLIES(a_done_state, o_done, (r_state == S_APPLY) || (r_state == S_OUT), "result outside finishing states")
    `ASSERT_IMPLIES(a_idle_no_write, r_state == S_IDLE, !o_mem_we, "cell store written while idle")
    `ASSERT_IMPLIES(a_wpend_scroll, r_wpend, r_state == S_SCROLL, "copy write pending outside scroll")
    `ASSERT_NEXT(a_cursor_on_screen, (r_state == S_APPLY) && upd, (CXW'(r_col) < CXW'(r_nc)) && (NRW'(r_row) < r_nr), "cursor left the screen after a put")

endmodule

FILE: rtl/core/text_console_char_writer.sv
`timescale 1ns / 1ps

// Text console cell writer.
// Input stream (i_s_*): one beat per action: put character, clear screen or read cell.
// Output stream (o_m_*): one beat per input beat, in order, with the cursor after the
// action and, for a read, the addressed cell.
// Configuration channel (i_cfg_*): colours and screen size, always ready; write only
// while no action is in flight.
// For a put, a read or an unused action the beat is accepted, then the cell store is
// written or its registered read port delivers the cell.
// A put that scrolls then has the store copy one cell a cycle through its single
// read and write port, then blank the bottom row.
// A clear then blanks the cells of the screen one cell a cycle.
// After reset all MAX_COLUMNS*MAX_ROWS cells of the store (4096 by default) are blanked
// one cell a cycle while o_s_tready stays low; the cursor starts at column 0, row 0.
// The result sits in an output register: the next input beat is accepted and worked
// while it waits, and only the hand-over of a further result waits for i_m_tready.
module text_console_char_writer #(
    parameter int MAX_COLUMNS = tccw_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = tccw_pkg::MAX_ROWS_DEF,
    parameter int TAB_STOP    = tccw_pkg::TAB_STOP_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [tccw_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tccw_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // action [1:0], char_code [9:2], cell_index [21:10]
    input  logic [tccw_pkg::S_TDATA_W-1:0]     i_s_tdata,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // cursor_column [6:0], cursor_row [11:7], read_char [19:12], read_attribute [27:20]
    output logic [tccw_pkg::M_TDATA_W-1:0]     o_m_tdata
);

    localparam int DEPTH  = MAX_COLUMNS * MAX_ROWS;
    localparam int AW     = $clog2(DEPTH);
    localparam int ITEM_W = $bits(tccw_pkg::t_item);
    localparam int CELL_W = tccw_pkg::CELL_W;
    localparam int M_W    = tccw_pkg::M_TDATA_W;

    tccw_pkg::t_cfg    r_cfg;
    tccw_pkg::t_item   item;
    tccw_pkg::t_result res;
    logic              r_m_tvalid;
    logic [M_W-1:0]    r_m_tdata;
    logic              out_free;
    logic              done;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [CELL_W-1:0] mem_rdata;

    assign o_cfg_ready = 1'b1;
    assign item        = tccw_pkg::t_item'(i_s_tdata[ITEM_W-1:0]);
    assign out_free    = !r_m_tvalid || i_m_tready;
    assign o_m_tvalid  = r_m_tvalid;
    assign o_m_tdata   = r_m_tdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.background <= tccw_pkg::BACKGROUND_RESET;
            r_cfg.foreground <= tccw_pkg::FOREGROUND_RESET;
            r_cfg.columns    <= tccw_pkg::COLUMNS_RESET;
            r_cfg.rows       <= tccw_pkg::ROWS_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tccw_pkg::REG_BACKGROUND: r_cfg.background <= i_cfg_data[3:0];
                tccw_pkg::REG_FOREGROUND: r_cfg.foreground <= i_cfg_data[3:0];
                tccw_pkg::REG_COLUMNS:    r_cfg.columns    <= i_cfg_data[7:0];
                tccw_pkg::REG_ROWS:       r_cfg.rows       <= i_cfg_data[5:0];
                default:                  r_cfg            <= r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (done) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_m_tdata <= M_W'(res);
        end
    end

    tccw_seq #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS),
        .TAB_STOP    (TAB_STOP)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (i_s_tvalid),
        .i_item      (item),
        .o_ready     (o_s_tready),
        .i_out_free  (out_free),
        .o_done      (done),
        .o_res       (res),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    tccw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (DEPTH)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule

FILE: sim/text_console_char_writer_tb.sv
`timescale 1ns / 1ps

module text_console_char_writer_tb;

    localparam int ACT_W         = tccw_pkg::ACTION_W;
    localparam int CH_W          = tccw_pkg::CHAR_W;
    localparam int IDX_W         = tccw_pkg::INDEX_W;
    localparam int CFG_DW        = tccw_pkg::CFG_DATA_W;
    localparam int SD_W          = tccw_pkg::S_TDATA_W;
    localparam int MAX_C         = tccw_pkg::MAX_COLUMNS_DEF;
    localparam int MAX_R         = tccw_pkg::MAX_ROWS_DEF;
    localparam int TAB_S         = tccw_pkg::TAB_STOP_DEF;
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 20;
    localparam int STORE_CELLS   = MAX_C * MAX_R;

    typedef enum logic [1:0] {STEP_BEAT, STEP_REG, STEP_DRAIN} t_step_kind;

    typedef struct {
        t_step_kind                       kind;
        tccw_pkg::t_item                  beat;
        logic [tccw_pkg::CFG_IDX_W-1:0]   reg_index;
        logic [CFG_DW-1:0]                reg_value;
    } t_console_step;

    logic                             i_clk       = 1'b0;
    logic                             i_rst_n     = 1'b0;
    logic                             i_cfg_valid = 1'b0;
    logic                             o_cfg_ready;
    logic [tccw_pkg::CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DW-1:0]                i_cfg_data  = '0;
    logic                             i_s_tvalid  = 1'b0;
    logic                             o_s_tready;
    logic [SD_W-1:0]                  i_s_tdata   = '0;
    logic                             o_m_tvalid;
    logic                             i_m_tready  = 1'b0;
    logic [tccw_pkg::M_TDATA_W-1:0]   o_m_tdata;

    t_console_step     pending_steps[$];
    tccw_pkg::t_result expected_reports[$];

    logic [tccw_pkg::CELL_W-1:0] shadow_cells [0:STORE_CELLS-1];
    int unsigned       cur_col;
    int unsigned       cur_row;
    logic [3:0]        bg_colour;
    logic [3:0]        fg_colour;
    logic [7:0]        screen_cols;
    logic [5:0]        screen_rows;

    logic s_fire   = 1'b0;
    logic cfg_fire = 1'b0;
    logic link_up  = 1'b0;
    int   in_beats = 0;
    int   fail_count = 0;

    int   src_gap = 0;
    int   src_calm = 0;
    int   quiet_cycles = 0;
    int   sink_gap = 0;
    int   sink_calm = 0;
    int   hold_left = 0;
    bit   hold_done = 1'b0;

    text_console_char_writer u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic tccw_pkg::t_result apply_console_action(input tccw_pkg::t_item it);
        tccw_pkg::t_result res;
        int unsigned nc;
        int unsigned nr;
        int unsigned col;
        int unsigned row;
        int unsigned k;
        res = '0;
        nc = (screen_cols == 0) ? 1 :
             (screen_cols > MAX_C) ? MAX_C : screen_cols;
        nr = (screen_rows == 0) ? 1 :
             (screen_rows > MAX_R) ? MAX_R : screen_rows;
        case (it.action)
            tccw_pkg::ACT_PUT: begin
                if (it.char_code != tccw_pkg::CH_NUL) begin
                    col = (cur_col >= nc) ? nc - 1 : cur_col;
                    row = (cur_row >= nr) ? nr - 1 : cur_row;
                    if (it.char_code == tccw_pkg::CH_TAB) begin
                        col = col + TAB_S - (col % TAB_S);
                    end else if (it.char_code == tccw_pkg::CH_NEWLINE) begin
                        col = 0;
                        row = row + 1;
                    end else begin
                        shadow_cells[row * nc + col] = {bg_colour, fg_colour, it.char_code};
                        col = col + 1;
                    end
                    if (col >= nc) begin
                        col = 0;
                        row = row + 1;
                    end
                    if (row >= nr) begin
                        row = nr - 1;
                        for (k = 0; k < nc * (nr - 1); k++)
                            shadow_cells[k] = shadow_cells[k + nc];
                        for (k = nc * (nr - 1); k < nc * nr; k++)
                            shadow_cells[k] = '0;
                    end
                    cur_col = col;
                    cur_row = row;
                end
            end
            tccw_pkg::ACT_CLEAR: begin
                for (k = 0; k < nc * nr; k++)
                    shadow_cells[k] = '0;
            end
            tccw_pkg::ACT_READ: begin
                res.read_char      = shadow_cells[it.cell_index][7:0];
                res.read_attribute = shadow_cells[it.cell_index][15:8];
            end
            default: begin
            end
        endcase
        res.cursor_column = cur_col[tccw_pkg::COL_OUT_W-1:0];
        res.cursor_row    = cur_row[tccw_pkg::ROW_OUT_W-1:0];
        return res;
    endfunction

    task automatic add_beat(input logic [ACT_W-1:0] act, input logic [CH_W-1:0] ch,
                            input logic [IDX_W-1:0] idx);
        t_console_step s;
        s.kind             = STEP_BEAT;
        s.beat.action      = act;
        s.beat.char_code   = ch;
        s.beat.cell_index  = idx;
        s.reg_index        = '0;
        s.reg_value        = '0;
        pending_steps.push_back(s);
    endtask

    task automatic add_reg_write(input logic [tccw_pkg::CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DW-1:0] val);
        t_console_step s;
        s.kind      = STEP_REG;
        s.beat      = '0;
        s.reg_index = idx;
        s.reg_value = val;
        pending_steps.push_back(s);
    endtask

    task automatic add_drain();
        t_console_step s;
        s.kind      = STEP_DRAIN;
        s.beat      = '0;
        s.reg_index = '0;
        s.reg_value = '0;
        pending_steps.push_back(s);
    endtask

    // Mostly text with line control and reads of visible cells; the rest is noise.
    task automatic add_text_beat(input int nc, input int nr, input bit big);
        int               r;
        logic [ACT_W-1:0] act;
        logic [CH_W-1:0]  ch;
        logic [IDX_W-1:0] idx;
        r   = $urandom_range(0, 99);
        act = tccw_pkg::ACT_PUT;
        ch  = CH_W'($urandom_range(0, 255));
        idx = IDX_W'($urandom_range(0, STORE_CELLS - 1));
        if (r < 45) begin
            ch = CH_W'($urandom_range(32, 126));
        end else if (r < 52) begin
        end else if (r < 62) begin
            ch = tccw_pkg::CH_NEWLINE;
        end else if (r < 69) begin
            ch = tccw_pkg::CH_TAB;
        end else if (r < 71) begin
            ch = tccw_pkg::CH_NUL;
        end else if (r < 88) begin
            act = tccw_pkg::ACT_READ;
            idx = IDX_W'($urandom_range(0, nr - 1) * nc + $urandom_range(0, nc - 1));
        end else if (r < 93) begin
            act = tccw_pkg::ACT_READ;
        end else if (r < 97 && !big) begin
            act = tccw_pkg::ACT_CLEAR;
        end else begin
            act = ACT_UNUSED;
        end
        add_beat(act, ch, idx);
    endtask

    always @(posedge i_clk) begin : watch
        tccw_pkg::t_result got;
        tccw_pkg::t_result want;
        s_fire   <= i_rst_n && i_s_tvalid && o_s_tready;
        cfg_fire <= i_rst_n && i_cfg_valid && o_cfg_ready;
        if (i_rst_n && o_s_tready)
            link_up <= 1'b1;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = tccw_pkg::t_result'(o_m_tdata[$bits(tccw_pkg::t_result)-1:0]);
            if (expected_reports.size() == 0) begin
                if (fail_count < 10)
                    $display("unexpected result beat: col %0d row %0d char %h attr %h",
                             got.cursor_column, got.cursor_row, got.read_char,
                             got.read_attribute);
                fail_count++;
            end else begin
                want = expected_reports.pop_front();
                if (got !== want) begin
                    if (fail_count < 10)
                        $display({"mismatch: col %0d/%0d row %0d/%0d char %h/%h attr %h/%h",
                                  " (expected/actual)"},
                                 want.cursor_column, got.cursor_column,
                                 want.cursor_row, got.cursor_row,
                                 want.read_char, got.read_char,
                                 want.read_attribute, got.read_attribute);
                    fail_count++;
                end
            end
        end
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                tccw_pkg::REG_BACKGROUND: bg_colour   = i_cfg_data[3:0];
                tccw_pkg::REG_FOREGROUND: fg_colour   = i_cfg_data[3:0];
                tccw_pkg::REG_COLUMNS:    screen_cols = i_cfg_data[7:0];
                tccw_pkg::REG_ROWS:       screen_rows = i_cfg_data[5:0];
                default: begin
                end
            endcase
        end
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            expected_reports.push_back(apply_console_action(
                tccw_pkg::t_item'(i_s_tdata[$bits(tccw_pkg::t_item)-1:0])));
            in_beats <= in_beats + 1;
        end
    end

    always @(negedge i_clk) begin : drive
        logic                           s_valid_n;
        logic [SD_W-1:0]                s_data_n;
        logic                           c_valid_n;
        logic [tccw_pkg::CFG_IDX_W-1:0] c_idx_n;
        logic [CFG_DW-1:0]              c_data_n;
        t_console_step                  s;
        s_valid_n = i_s_tvalid;
        s_data_n  = i_s_tdata;
        c_valid_n = i_cfg_valid;
        c_idx_n   = i_cfg_index;
        c_data_n  = i_cfg_data;
        if (s_fire) begin
            s_valid_n = 1'b0;
            if (src_calm > 0)
                src_calm--;
            else if ($urandom_range(0, 49) == 0)
                src_calm = $urandom_range(20, 60);
            src_gap = (src_calm > 0) ? 0 : pick_gap();
        end
        if (cfg_fire)
            c_valid_n = 1'b0;
        if (expected_reports.size() == 0 && !s_valid_n && !c_valid_n)
            quiet_cycles++;
        else
            quiet_cycles = 0;
        if (link_up && !s_valid_n && !c_valid_n) begin
            if (src_gap > 0) begin
                src_gap--;
            end else if (pending_steps.size() != 0) begin
                s = pending_steps[0];
                case (s.kind)
                    STEP_BEAT: begin
                        s_valid_n = 1'b1;
                        s_data_n  = SD_W'(s.beat);
                        void'(pending_steps.pop_front());
                    end
                    STEP_REG: begin
                        if (quiet_cycles >= SETTLE_CYCLES) begin
                            c_valid_n = 1'b1;
                            c_idx_n   = s.reg_index;
                            c_data_n  = s.reg_value;
                            void'(pending_steps.pop_front());
                        end
                    end
                    default: begin
                        if (quiet_cycles >= SETTLE_CYCLES)
                            void'(pending_steps.pop_front());
                    end
                endcase
            end
        end
        i_s_tvalid  <= s_valid_n;
        i_s_tdata   <= s_data_n;
        i_cfg_valid <= c_valid_n;
        i_cfg_index <= c_idx_n;
        i_cfg_data  <= c_data_n;
    end

    // Once in the run the output side holds off long enough for the block to fill up.
    always @(negedge i_clk) begin : sink
        if (!hold_done && in_beats >= 250) begin
            hold_done = 1'b1;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
            if (sink_calm > 0)
                sink_calm--;
            else if ($urandom_range(0, 49) == 0)
                sink_calm = $urandom_range(20, 60);
            sink_gap = (sink_calm > 0) ? 0 : pick_gap();
        end
    end

    initial begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin : run
        int ph;
        int n;
        int cols_v;
        int rows_v;
        int nc;
        int nr;
        int count;
        bit big;
        for (n = 0; n < STORE_CELLS; n++)
            shadow_cells[n] = '0;
        cur_col     = 0;
        cur_row     = 0;
        bg_colour   = tccw_pkg::BACKGROUND_RESET;
        fg_colour   = tccw_pkg::FOREGROUND_RESET;
        screen_cols = tccw_pkg::COLUMNS_RESET;
        screen_rows = tccw_pkg::ROWS_RESET;

        add_beat(tccw_pkg::ACT_PUT, 8'h48, 12'h000);
        add_beat(tccw_pkg::ACT_PUT, 8'hFF, 12'hFFF);
        add_beat(tccw_pkg::ACT_PUT, tccw_pkg::CH_NUL, 12'h000);
        add_beat(tccw_pkg::ACT_PUT, tccw_pkg::CH_TAB, 12'h000);
        add_beat(tccw_pkg::ACT_PUT, tccw_pkg::CH_NEWLINE, 12'h000);
        add_beat(tccw_pkg::ACT_READ, 8'h00, 12'd0);
        add_beat(tccw_pkg::ACT_READ, 8'h00, 12'd1);
        add_beat(tccw_pkg::ACT_READ, 8'hFF, 12'hFFF);
        add_beat(ACT_UNUSED, 8'hFF, 12'hFFF);
        add_beat(tccw_pkg::ACT_CLEAR, 8'h00, 12'h000);
        add_beat(tccw_pkg::ACT_READ, 8'h00, 12'd0);

        add_reg_write(tccw_pkg::REG_BACKGROUND, 8'hFF);
        add_reg_write(tccw_pkg::REG_FOREGROUND, 8'hF0);
        add_reg_write(tccw_pkg::REG_COLUMNS, 8'd8);
        add_reg_write(tccw_pkg::REG_ROWS, 8'd2);
        add_beat(tccw_pkg::ACT_PUT, tccw_pkg::CH_TAB, 12'h000);
        add_beat(tccw_pkg::ACT_PUT, tccw_pkg::CH_NEWLINE, 12'h000);
        for (n = 0; n < 5; n++)
            add_beat(tccw_pkg::ACT_PUT, CH_W'(8'h61 + n), 12'h000);
        add_beat(tccw_pkg::ACT_READ, 8'h00, 12'd8);

        // The cursor now lies beyond the new, narrower screen.
        add_reg_write(tccw_pkg::REG_COLUMNS, 8'd3);
        add_reg_write(tccw_pkg::REG_ROWS, 8'hC1);
        add_beat(tccw_pkg::ACT_READ, 8'h00, 12'd0);
        add_beat(tccw_pkg::ACT_PUT, tccw_pkg::CH_NUL, 12'h000);
        add_beat(tccw_pkg::ACT_PUT, 8'h78, 12'h000);
        add_beat(tccw_pkg::ACT_READ, 8'h00, 12'd0);

        for (ph = 0; ph < 12; ph++) begin
            big = (ph == 3 || ph == 7);
            if (ph == 0) begin
                cols_v = 0;
                rows_v = 0;
            end else if (ph == 3) begin
                cols_v = MAX_C;
                rows_v = MAX_R;
            end else if (ph == 7) begin
                cols_v = 255;
                rows_v = 63;
            end else begin
                cols_v = $urandom_range(0, 12);
                rows_v = $urandom_range(0, 6);
            end
            add_reg_write(tccw_pkg::REG_BACKGROUND, CFG_DW'($urandom_range(0, 255)));
            add_reg_write(tccw_pkg::REG_FOREGROUND, CFG_DW'($urandom_range(0, 255)));
            add_reg_write(tccw_pkg::REG_COLUMNS, cols_v[7:0]);
            add_reg_write(tccw_pkg::REG_ROWS, {2'($urandom_range(0, 3)), rows_v[5:0]});
            nc = (cols_v == 0) ? 1 : (cols_v > MAX_C) ? MAX_C : cols_v;
            nr = (rows_v == 0) ? 1 : (rows_v > MAX_R) ? MAX_R : rows_v;
            count = big ? 40 : 90;
            for (n = 0; n < count; n++) begin
                if (n == count / 2)
                    add_drain();
                add_text_beat(nc, nr, big);
            end
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_steps.size() != 0 || i_s_tvalid || i_cfg_valid ||
               expected_reports.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && expected_reports.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
